### hdl/bfra_pkg.sv
// shared types, codes and defaults of the best-fit range allocator
package bfra_pkg;

	// default sizes
	localparam int MAX_SLOTS_DEF   = 4096;
	localparam int MAX_RANGES_DEF  = 64;
	localparam int MAX_PENDING_DEF = 64;
	localparam int FENCE_W         = 64;
	localparam int STATUS_W        = 3;
	localparam int CMD_W           = 2;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_DEFER = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_ZERO      = 3'd2,
		ST_QFULL     = 3'd3,
		ST_TFULL     = 3'd4
	} status_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_A_SCAN,
		S_A_CARVE,
		S_A_SHIFT,
		S_R_CLIP,
		S_R_STEP,
		S_R_OK,
		S_R_FAIL,
		S_F_FETCH,
		S_F_EVAL,
		S_RESP
	} state_t;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DEFER,
		OP_SCAN,
		OP_CARVE,
		OP_SHIFT,
		OP_SHIFT_END,
		OP_REL_CLIP,
		OP_REL_STEP,
		OP_REL_RESTART,
		OP_REL_COMMIT,
		OP_FL_REL,
		OP_FL_KEEP,
		OP_FL_DONE,
		OP_FL_END
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t  op;
		logic    st_we;
		status_t st;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic cnt_zero;
		logic q_full;
		logic scan_more;
		logic best_v;
		logic carve_zero;
		logic shift_more;
		logic clip_out;
		logic rel_end;
		logic wpass;
		logic over;
		logic fl_more;
		logic fl_match;
	} dp_sts_t;

endpackage

### hdl/best_fit_range_allocator_core.sv
// top level of the best-fit range allocator
// Usage:
//   Commands enter on start with cmd, index, count and fence; an item is taken
//   at a clock edge with start high and busy low. Each item gives one result on
//   status, base, in_use and released, shown for exactly one cycle with done
//   high; the receiver cannot stall it.
//   capacity is written through cfg_we/cfg_wdata while busy is low; it resets
//   the free table to one range (none at zero) and clears the used count and defer queue.
// Operation:
//   allocate: a best-fit scan of the range table and a carve, plus a shift
//   of the later entries when a range empties. free: a counting pass and a
//   merge pass over the range table, one entry per cycle through its single
//   read port. defer: one queue write. flush: frees each queued item with a
//   fence at or below the given one. The port and the merge set the pace.
// Reset:
//   capacity returns to MAX_SLOTS, the pool holds one free range covering it,
//   the queue and used count are empty. No clearing pass is needed.
module best_fit_range_allocator_core #(
	parameter int MAX_SLOTS   = bfra_pkg::MAX_SLOTS_DEF,
	parameter int MAX_RANGES  = bfra_pkg::MAX_RANGES_DEF,
	parameter int MAX_PENDING = bfra_pkg::MAX_PENDING_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]     cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic [bfra_pkg::CMD_W-1:0]         cmd,
	input  logic [$clog2(MAX_SLOTS)-1:0]       index,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]     count,
	input  logic [bfra_pkg::FENCE_W-1:0]       fence,
	output logic                               done,
	output logic [bfra_pkg::STATUS_W-1:0]      status,
	output logic [$clog2(MAX_SLOTS)-1:0]       base,
	output logic [$clog2(MAX_SLOTS+1)-1:0]     in_use,
	output logic [$clog2(MAX_PENDING+1)-1:0]   released
);
	import bfra_pkg::*;

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// sequencer
	bfra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// tables and counters
	bfra_dp #(
		.MAX_SLOTS   (MAX_SLOTS),
		.MAX_RANGES  (MAX_RANGES),
		.MAX_PENDING (MAX_PENDING)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.index     (index),
		.count     (count),
		.fence     (fence),
		.ctl       (ctl),
		.sts       (sts),
		.status    (status),
		.base      (base),
		.in_use    (in_use),
		.released  (released)
	);

endmodule

### hdl/bfra_ctrl.sv
// controller state machine of the best-fit range allocator
module bfra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bfra_pkg::dp_sts_t  sts,
	output bfra_pkg::ctl_cmd_t ctl,
	output logic               busy,
	output logic               done
);
	import bfra_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		ctl.op    = OP_NONE;
		ctl.st_we = 1'b0;
		ctl.st    = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.cmd != CMD_FLUSH && sts.cnt_zero) begin
					ctl.st_we = 1'b1;
					ctl.st    = ST_ZERO;
					state_d   = S_RESP;
				end else begin
					case (sts.cmd)
						CMD_ALLOC: state_d = S_A_SCAN;
						CMD_FREE:  state_d = S_R_CLIP;
						CMD_DEFER: begin
							if (sts.q_full) begin
								ctl.st_we = 1'b1;
								ctl.st    = ST_QFULL;
							end else begin
								ctl.op = OP_DEFER;
							end
							state_d = S_RESP;
						end
						default:   state_d = S_F_FETCH;
					endcase
				end
			end
			S_A_SCAN: begin
				if (sts.scan_more) begin
					ctl.op = OP_SCAN;
				end else if (sts.best_v) begin
					state_d = S_A_CARVE;
				end else begin
					ctl.st_we = 1'b1;
					ctl.st    = ST_EXHAUSTED;
					state_d   = S_RESP;
				end
			end
			S_A_CARVE: begin
				ctl.op  = OP_CARVE;
				state_d = sts.carve_zero ? S_A_SHIFT : S_RESP;
			end
			S_A_SHIFT: begin
				if (sts.shift_more) begin
					ctl.op = OP_SHIFT;
				end else begin
					ctl.op  = OP_SHIFT_END;
					state_d = S_RESP;
				end
			end
			S_R_CLIP: begin
				ctl.op  = OP_REL_CLIP;
				state_d = sts.clip_out ? S_R_OK : S_R_STEP;
			end
			S_R_STEP: begin
				if (!sts.rel_end) begin
					ctl.op = OP_REL_STEP;
				end else if (!sts.wpass) begin
					if (sts.over) begin
						state_d = S_R_FAIL;
					end else begin
						ctl.op = OP_REL_RESTART;
					end
				end else begin
					ctl.op  = OP_REL_COMMIT;
					state_d = S_R_OK;
				end
			end
			S_R_OK: begin
				if (sts.cmd == CMD_FLUSH) begin
					ctl.op  = OP_FL_DONE;
					state_d = S_F_FETCH;
				end else begin
					state_d = S_RESP;
				end
			end
			S_R_FAIL: begin
				ctl.st_we = 1'b1;
				ctl.st    = ST_TFULL;
				if (sts.cmd == CMD_FLUSH) begin
					ctl.op  = OP_FL_KEEP;
					state_d = S_F_FETCH;
				end else begin
					state_d = S_RESP;
				end
			end
			S_F_FETCH: begin
				if (sts.fl_more) begin
					state_d = S_F_EVAL;
				end else begin
					ctl.op  = OP_FL_END;
					state_d = S_RESP;
				end
			end
			S_F_EVAL: begin
				if (sts.fl_match) begin
					ctl.op  = OP_FL_REL;
					state_d = S_R_CLIP;
				end else begin
					ctl.op  = OP_FL_KEEP;
					state_d = S_F_FETCH;
				end
			end
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// handshake
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

### hdl/bfra_dp.sv
// datapath of the best-fit range allocator: range table, defer queue, counters
module bfra_dp #(
	parameter int MAX_SLOTS   = bfra_pkg::MAX_SLOTS_DEF,
	parameter int MAX_RANGES  = bfra_pkg::MAX_RANGES_DEF,
	parameter int MAX_PENDING = bfra_pkg::MAX_PENDING_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]     cfg_wdata,
	input  logic [bfra_pkg::CMD_W-1:0]         cmd,
	input  logic [$clog2(MAX_SLOTS)-1:0]       index,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]     count,
	input  logic [bfra_pkg::FENCE_W-1:0]       fence,
	input  bfra_pkg::ctl_cmd_t                 ctl,
	output bfra_pkg::dp_sts_t                  sts,
	output logic [bfra_pkg::STATUS_W-1:0]      status,
	output logic [$clog2(MAX_SLOTS)-1:0]       base,
	output logic [$clog2(MAX_SLOTS+1)-1:0]     in_use,
	output logic [$clog2(MAX_PENDING+1)-1:0]   released
);
	import bfra_pkg::*;

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int RA = $clog2(MAX_RANGES);
	localparam int RC = $clog2(MAX_RANGES + 1);
	localparam int MC = $clog2(MAX_RANGES + 2);
	localparam int PA = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
	localparam int PC = $clog2(MAX_PENDING + 1);
	localparam logic [CW-1:0] CAP_MAX  = CW'(MAX_SLOTS);
	localparam logic [CW-1:0] USED_MAX = {CW{1'b1}};
	localparam logic [MC-1:0] M_LIMIT  = MC'(MAX_RANGES);
	localparam logic [PC-1:0] P_LIMIT  = PC'(MAX_PENDING);

	// memories
	logic [IW-1:0]      rs_mem [MAX_RANGES];
	logic [CW-1:0]      rl_mem [MAX_RANGES];
	logic [IW-1:0]      ps_mem [MAX_PENDING];
	logic [CW-1:0]      pl_mem [MAX_PENDING];
	logic [FENCE_W-1:0] pf_mem [MAX_PENDING];

	// control registers
	logic [CW-1:0] cap_q;
	logic [RC-1:0] rtotal_q;
	logic [PC-1:0] ptotal_q;
	logic [CW-1:0] used_q;
	logic          e0_init_q;
	logic          e0_hit_q;

	// per-item registers
	cmd_t               cmd_q;
	logic [IW-1:0]      idx_q;
	logic [CW-1:0]      cnt_q;
	logic [FENCE_W-1:0] fence_q;
	logic [RC-1:0]      i_q;
	logic               best_v_q;
	logic [RA-1:0]      best_q;
	logic [IW-1:0]      best_s_q;
	logic [CW-1:0]      best_l_q;
	logic [IW-1:0]      rel_s_q;
	logic [CW-1:0]      rel_l_q;
	logic [MC-1:0]      m_q;
	logic               placed_q;
	logic               wpass_q;
	logic [IW-1:0]      acc_s_q;
	logic [CW-1:0]      acc_l_q;
	logic [PC-1:0]      j_q;
	logic [PC-1:0]      keep_q;
	logic [PC-1:0]      relcnt_q;
	status_t            res_status_q;
	logic [IW-1:0]      res_base_q;

	// read data
	logic [IW-1:0]      rd_raw_s_q;
	logic [CW-1:0]      rd_raw_l_q;
	logic [IW-1:0]      pd_s_q;
	logic [CW-1:0]      pd_l_q;
	logic [FENCE_W-1:0] pd_f_q;
	logic [IW-1:0]      rd_s;
	logic [CW-1:0]      rd_l;

	// combinational datapath values
	logic [RC:0]        i_ext;
	logic [RC:0]        ra_full;
	logic [RA-1:0]      r_raddr;
	logic               r_we;
	logic [RA-1:0]      r_waddr;
	logic [IW-1:0]      r_ws;
	logic [CW-1:0]      r_wl;
	logic               p_we;
	logic [PA-1:0]      p_waddr;
	logic [IW-1:0]      p_ws;
	logic [CW-1:0]      p_wl;
	logic [FENCE_W-1:0] p_wf;
	logic [CW-1:0]      clip_rem;
	logic [CW-1:0]      clip_len;
	logic               clip_out;
	logic               at_end;
	logic               ins;
	logic [IW-1:0]      e_s;
	logic [CW-1:0]      e_l;
	logic [CW:0]        acc_end;
	logic               touch;
	logic               take;
	logic [CW-1:0]      new_len;
	logic [CW:0]        used_add;
	logic [CW-1:0]      used_sat;
	logic [CW-1:0]      used_sub;
	logic [CW-1:0]      cap_new;
	logic [MC-1:0]      m_dec;

	// entry zero holds the whole pool until first written
	assign rd_s = e0_hit_q ? '0 : rd_raw_s_q;
	assign rd_l = e0_hit_q ? cap_q : rd_raw_l_q;

	// clipping, merging, best-fit and counter arithmetic
	always_comb begin
		i_ext    = {1'b0, i_q};
		clip_rem = cap_q - CW'(rel_s_q);
		clip_len = (rel_l_q > clip_rem) ? clip_rem : rel_l_q;
		clip_out = (CW'(rel_s_q) >= cap_q) || (clip_len == '0);
		at_end   = (i_q == rtotal_q);
		ins      = at_end ? !placed_q : (!placed_q && (rd_s > rel_s_q));
		e_s      = ins ? rel_s_q : rd_s;
		e_l      = ins ? rel_l_q : rd_l;
		acc_end  = (CW+1)'(acc_s_q) + (CW+1)'(acc_l_q);
		touch    = (m_q != '0) && (acc_end == (CW+1)'(e_s));
		take     = (rd_l >= cnt_q) && (!best_v_q || (rd_l < best_l_q));
		new_len  = best_l_q - cnt_q;
		used_add = (CW+1)'(used_q) + (CW+1)'(cnt_q);
		used_sat = used_add[CW] ? USED_MAX : used_add[CW-1:0];
		used_sub = (used_q >= rel_l_q) ? (used_q - rel_l_q) : '0;
		cap_new  = (cfg_wdata > CAP_MAX) ? CAP_MAX : cfg_wdata;
		m_dec    = m_q - MC'(1);
	end

	// range table read address for the next cycle
	always_comb begin
		case (ctl.op)
			OP_LOAD, OP_REL_CLIP, OP_REL_RESTART: ra_full = '0;
			OP_SCAN:     ra_full = i_ext + (RC+1)'(1);
			OP_CARVE:    ra_full = (RC+1)'(best_q) + (RC+1)'(1);
			OP_SHIFT:    ra_full = i_ext + (RC+1)'(2);
			OP_REL_STEP: ra_full = ins ? i_ext : (i_ext + (RC+1)'(1));
			default:     ra_full = i_ext;
		endcase
		r_raddr = ra_full[RA-1:0];
	end

	// range table write port
	always_comb begin
		r_we    = 1'b0;
		r_waddr = '0;
		r_ws    = '0;
		r_wl    = '0;
		if (cfg_we) begin
			r_we = 1'b1;
			r_wl = cap_new;
		end else begin
			case (ctl.op)
				OP_CARVE: begin
					r_we    = (new_len != '0);
					r_waddr = best_q;
					r_ws    = best_s_q + IW'(cnt_q);
					r_wl    = new_len;
				end
				OP_SHIFT: begin
					r_we    = 1'b1;
					r_waddr = i_q[RA-1:0];
					r_ws    = rd_s;
					r_wl    = rd_l;
				end
				OP_REL_STEP: begin
					r_we    = wpass_q && !touch && (m_q != '0);
					r_waddr = m_dec[RA-1:0];
					r_ws    = acc_s_q;
					r_wl    = acc_l_q;
				end
				OP_REL_COMMIT: begin
					r_we    = 1'b1;
					r_waddr = m_dec[RA-1:0];
					r_ws    = acc_s_q;
					r_wl    = acc_l_q;
				end
				default: r_we = 1'b0;
			endcase
		end
	end

	// defer queue write port
	always_comb begin
		p_we    = 1'b0;
		p_waddr = '0;
		p_ws    = idx_q;
		p_wl    = cnt_q;
		p_wf    = fence_q;
		case (ctl.op)
			OP_DEFER: begin
				p_we    = 1'b1;
				p_waddr = ptotal_q[PA-1:0];
			end
			OP_FL_KEEP: begin
				p_we    = 1'b1;
				p_waddr = keep_q[PA-1:0];
				p_ws    = pd_s_q;
				p_wl    = pd_l_q;
				p_wf    = pd_f_q;
			end
			default: p_we = 1'b0;
		endcase
	end

	// range table memory
	always_ff @(posedge clk) begin
		if (r_we) begin
			rs_mem[r_waddr] <= r_ws;
			rl_mem[r_waddr] <= r_wl;
		end
		rd_raw_s_q <= rs_mem[r_raddr];
		rd_raw_l_q <= rl_mem[r_raddr];
	end

	// defer queue memory
	always_ff @(posedge clk) begin
		if (p_we) begin
			ps_mem[p_waddr] <= p_ws;
			pl_mem[p_waddr] <= p_wl;
			pf_mem[p_waddr] <= p_wf;
		end
		pd_s_q <= ps_mem[j_q[PA-1:0]];
		pd_l_q <= pl_mem[j_q[PA-1:0]];
		pd_f_q <= pf_mem[j_q[PA-1:0]];
	end

	// pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_MAX;
			rtotal_q  <= RC'(1);
			ptotal_q  <= '0;
			used_q    <= '0;
			e0_init_q <= 1'b1;
			e0_hit_q  <= 1'b0;
		end else begin
			e0_hit_q <= e0_init_q && (r_raddr == '0);
			if (r_we && (r_waddr == '0)) begin
				e0_init_q <= 1'b0;
			end
			if (cfg_we) begin
				cap_q    <= cap_new;
				rtotal_q <= (cap_new != '0) ? RC'(1) : '0;
				ptotal_q <= '0;
				used_q   <= '0;
			end else begin
				case (ctl.op)
					OP_DEFER:      ptotal_q <= ptotal_q + PC'(1);
					OP_CARVE:      used_q   <= used_sat;
					OP_SHIFT_END:  rtotal_q <= rtotal_q - RC'(1);
					OP_REL_COMMIT: begin
						rtotal_q <= RC'(m_q);
						used_q   <= used_sub;
					end
					OP_FL_END:     ptotal_q <= keep_q;
					default:       ptotal_q <= ptotal_q;
				endcase
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				cmd_q        <= cmd_t'(cmd);
				idx_q        <= index;
				cnt_q        <= count;
				fence_q      <= fence;
				rel_s_q      <= index;
				rel_l_q      <= count;
				i_q          <= '0;
				best_v_q     <= 1'b0;
				j_q          <= '0;
				keep_q       <= '0;
				relcnt_q     <= '0;
				res_base_q   <= '0;
				res_status_q <= ST_OK;
			end
			OP_SCAN: begin
				if (take) begin
					best_v_q <= 1'b1;
					best_q   <= i_q[RA-1:0];
					best_s_q <= rd_s;
					best_l_q <= rd_l;
				end
				i_q <= i_q + RC'(1);
			end
			OP_CARVE: begin
				res_base_q <= best_s_q;
				i_q        <= RC'(best_q);
			end
			OP_SHIFT: i_q <= i_q + RC'(1);
			OP_REL_CLIP: begin
				rel_l_q  <= clip_len;
				i_q      <= '0;
				m_q      <= '0;
				placed_q <= 1'b0;
				wpass_q  <= 1'b0;
			end
			OP_REL_STEP: begin
				if (touch) begin
					acc_l_q <= acc_l_q + e_l;
				end else begin
					acc_s_q <= e_s;
					acc_l_q <= e_l;
					m_q     <= m_q + MC'(1);
				end
				if (ins) begin
					placed_q <= 1'b1;
				end else begin
					i_q <= i_q + RC'(1);
				end
			end
			OP_REL_RESTART: begin
				i_q      <= '0;
				m_q      <= '0;
				placed_q <= 1'b0;
				wpass_q  <= 1'b1;
			end
			OP_FL_REL: begin
				rel_s_q <= pd_s_q;
				rel_l_q <= pd_l_q;
			end
			OP_FL_KEEP: begin
				keep_q <= keep_q + PC'(1);
				j_q    <= j_q + PC'(1);
			end
			OP_FL_DONE: begin
				relcnt_q <= relcnt_q + PC'(1);
				j_q      <= j_q + PC'(1);
			end
			default: i_q <= i_q;
		endcase
		if (ctl.st_we) begin
			res_status_q <= ctl.st;
		end
	end

	// status to the controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.cnt_zero   = (cnt_q == '0);
		sts.q_full     = (ptotal_q >= P_LIMIT);
		sts.scan_more  = (i_q < rtotal_q);
		sts.best_v     = best_v_q;
		sts.carve_zero = (new_len == '0);
		sts.shift_more = ((i_ext + (RC+1)'(1)) < (RC+1)'(rtotal_q));
		sts.clip_out   = clip_out;
		sts.rel_end    = at_end && placed_q;
		sts.wpass      = wpass_q;
		sts.over       = (m_q > M_LIMIT);
		sts.fl_more    = (j_q < ptotal_q);
		sts.fl_match   = (pd_f_q <= fence_q);
	end

	// result ports
	assign status   = res_status_q;
	assign base     = res_base_q;
	assign in_use   = used_q;
	assign released = relcnt_q;

endmodule

### hdl/bfra_checker.sv
// port checks of the best-fit range allocator, bound to the top level
module bfra_checker #(
	parameter int MAX_SLOTS   = bfra_pkg::MAX_SLOTS_DEF,
	parameter int MAX_PENDING = bfra_pkg::MAX_PENDING_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [bfra_pkg::STATUS_W-1:0]    status,
	input logic [$clog2(MAX_SLOTS)-1:0]     base,
	input logic [$clog2(MAX_PENDING+1)-1:0] released
);
	import bfra_pkg::*;

	// a taken item keeps the block busy and gives no result at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("item taken but block not busy");

	// one result per item; the result strobe does not stay high
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	// a command that fails carries no base
	a_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (base == '0))
		else $error("base nonzero on failed command");

	// released items only with ok or table full
	a_released: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (released != '0)) |-> ((status == ST_OK) || (status == ST_TFULL)))
		else $error("released count with wrong status");

endmodule

bind best_fit_range_allocator_core bfra_checker #(
	.MAX_SLOTS   (MAX_SLOTS),
	.MAX_PENDING (MAX_PENDING)
) u_bfra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.base     (base),
	.released (released)
);
